[rtl/core/snfcs_pkg.sv]
// Package for the SPI NOR flash command sequencer.
// Holds the phase type, operation and status codes, command bytes and the result beat type.
// No dependencies.
package snfcs_pkg;

  // Default geometry. Each of these must be a power of two.
  localparam int unsigned CapacityBytesDef = 8388608;
  localparam int unsigned PageBytesDef     = 256;
  localparam int unsigned SectorBytesDef   = 4096;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POLL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_MAKER      = 2'd1;
  localparam logic [1:0] CFG_CAPACITY   = 2'd2;

  // Configuration reset values.
  localparam logic [19:0] POLL_LIMIT_RST = 20'd1000000;
  localparam logic [7:0]  MAKER_RST      = 8'hEF;
  localparam logic [7:0]  CAPACITY_RST   = 8'h17;

  // Operation codes.
  localparam logic [2:0] OP_IDENTIFY = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_ERASE    = 3'd2;
  localparam logic [2:0] OP_PROGRAM  = 3'd3;
  localparam logic [2:0] OP_PG_BYTE  = 3'd4;
  localparam logic [2:0] OP_REPLY    = 3'd5;

  // Pending request codes.
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_ERASE   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_SPI  = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Done status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOINIT   = 3'd1;
  localparam logic [2:0] ST_BADARG   = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;

  // Flash command bytes.
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_PP      = 8'h02;
  localparam logic [7:0] CMD_SE      = 8'h20;
  localparam logic [7:0] CMD_RELEASE = 8'hAB;
  localparam logic [7:0] CMD_JEDEC   = 8'h9F;
  localparam logic [7:0] DUMMY_BYTE  = 8'hFF;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ID_WAKE, PH_ID_CMD, PH_ID_BYTE, PH_PRE_CMD, PH_PRE_ST,
    PH_POST_CMD, PH_POST_ST, PH_WREN, PH_CMD, PH_ADDR, PH_RD_DATA,
    PH_PG_WAIT, PH_PG_DATA
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mosi_byte;
    logic        frame_end;
    logic [23:0] value;
    logic [2:0]  status;
    logic        initialized;
    logic        last;
  } res_t;

  // Builds a result beat; initialized and last are filled in by the caller.
  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] mosi, logic fend,
                                  logic [23:0] val, logic [2:0] st);
    res_t r;
    r.kind        = kind;
    r.mosi_byte   = mosi;
    r.frame_end   = fend;
    r.value       = val;
    r.status      = st;
    r.initialized = 1'b0;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

[rtl/core/snfcs_in_if.sv]
// Input channel: host requests, program bytes and SPI replies.
// No dependencies.
interface snfcs_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [23:0] address;
  logic [23:0] length;
  logic [7:0]  byte_value;
  modport source (output valid, operation, address, length, byte_value, input ready);
  modport sink (input valid, operation, address, length, byte_value, output ready);
endinterface

[rtl/core/snfcs_out_if.sv]
// Result channel: SPI bytes, read data and done beats.
// No dependencies.
interface snfcs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  mosi_byte;
  logic        frame_end;
  logic [23:0] value;
  logic [2:0]  status;
  logic        initialized;
  logic        last;
  modport source (output valid, kind, mosi_byte, frame_end, value, status, initialized,
                  last, input ready);
  modport sink (input valid, kind, mosi_byte, frame_end, value, status, initialized,
                last, output ready);
endinterface

[rtl/core/snfcs_cfg_if.sv]
// Configuration write channel: register index and write data.
// No dependencies.
interface snfcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/snfcs_res_fifo.sv]
// Four-entry result queue that takes up to two beats and gives one per cycle while out_ready is high.
// Depends on snfcs_pkg.
module snfcs_res_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push0,
  input  logic             push1,
  input  snfcs_pkg::res_t  din0,
  input  snfcs_pkg::res_t  din1,
  output logic             room2,
  output logic             out_valid,
  input  logic             out_ready,
  output snfcs_pkg::res_t  dout,
  output logic [2:0]       count
);
  import snfcs_pkg::*;

  res_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign room2     = (cnt_r <= 3'd2);
  assign dout      = mem_r[rp_r];
  assign count     = cnt_r;

  // Pointer and fill bookkeeping; push1 is only used together with push0.
  always_comb begin
    wp_nxt  = wp_r + {1'b0, push0} + {1'b0, push1};
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {2'b0, push0} + {2'b0, push1} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push0) mem_r[wp_r] <= din0;
    if (push1) mem_r[wp_r + 2'd1] <= din1;
  end

endmodule

[rtl/core/spi_nor_flash_command_sequencer_core.sv]
// SPI NOR flash command sequencer, top level.
// With an empty result queue, the first result beat of an input beat is offered in the cycle
// after it is accepted, and a second beat, if any, is queued behind it.
// Throughput: one input beat per cycle while the result queue holds at most two beats; each input
// causes at most two result beats, and the four-entry queue drains one beat per cycle while out_ch.ready is high.
// Reset (rst_n, synchronous): phase idle, flag and identity cleared, registers to defaults.
// Depends on snfcs_pkg, the channel interfaces and snfcs_res_fifo.
module spi_nor_flash_command_sequencer_core #(
  parameter int unsigned CAPACITY_BYTES = snfcs_pkg::CapacityBytesDef,
  parameter int unsigned PAGE_BYTES     = snfcs_pkg::PageBytesDef,
  parameter int unsigned SECTOR_BYTES   = snfcs_pkg::SectorBytesDef
) (
  input logic          clk,
  input logic          rst_n,
  snfcs_in_if.sink     in_ch,
  snfcs_out_if.source  out_ch,
  snfcs_cfg_if.sink    cfg_ch
);
  import snfcs_pkg::*;

  localparam logic [24:0] CAP   = 25'(CAPACITY_BYTES);
  localparam logic [24:0] PAGE  = 25'(PAGE_BYTES);
  localparam logic [23:0] PMASK = 24'(PAGE_BYTES - 1);
  localparam logic [23:0] SMASK = 24'(SECTOR_BYTES - 1);

  // Configuration registers.
  logic [19:0] limit_r;
  logic [7:0]  maker_r, capc_r;

  // Sequencer state.
  phase_t      phase_r, phase_nxt;
  logic        flag_r, flag_nxt;
  logic [23:0] ident_r, ident_nxt;
  logic [23:0] addr_r, addr_nxt;
  logic [23:0] left_r, left_nxt;
  logic [19:0] pcnt_r, pcnt_nxt;
  logic [1:0]  fidx_r, fidx_nxt;
  logic [1:0]  preq_r, preq_nxt;

  res_t        res0, res1, r0f, r1f, head;
  logic [1:0]  nres;
  logic        accept, room2;
  logic [2:0]  qcount;
  logic        bad;
  logic [24:0] a25, l25;
  logic [23:0] left_dec, id_new;
  logic [19:0] pcnt_inc;
  logic [7:0]  b;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = room2;
  assign accept       = in_ch.valid && room2;
  assign b            = in_ch.byte_value;

  // Argument check for read, erase and program requests.
  always_comb begin
    a25 = {1'b0, in_ch.address};
    l25 = {1'b0, in_ch.length};
    bad = 1'b0;
    if (a25 >= CAP) begin
      bad = 1'b1;
    end else if (in_ch.operation == OP_ERASE) begin
      bad = ((in_ch.address & SMASK) != 24'd0);
    end else if (l25 == 25'd0 || l25 > CAP - a25) begin
      bad = 1'b1;
    end else if (in_ch.operation == OP_PROGRAM) begin
      bad = (l25 > PAGE) || ({1'b0, in_ch.address & PMASK} + l25 > PAGE);
    end
  end

  assign left_dec = (left_r != 24'd0) ? left_r - 24'd1 : 24'd0;
  assign id_new   = {ident_r[15:0], b};
  assign pcnt_inc = pcnt_r + 20'd1;

  // Next state and the result beats caused by the current input beat.
  always_comb begin
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    ident_nxt = ident_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    pcnt_nxt  = pcnt_r;
    fidx_nxt  = fidx_r;
    preq_nxt  = preq_r;
    nres      = 2'd0;
    res0      = '0;
    res1      = '0;
    if (in_ch.operation <= OP_PROGRAM) begin
      if (phase_r == PH_IDLE) begin
        preq_nxt = in_ch.operation[1:0];
        nres     = 2'd1;
        if (in_ch.operation == OP_IDENTIFY) begin
          flag_nxt  = 1'b0;
          ident_nxt = '0;
          res0      = mk_res(KIND_SPI, CMD_RELEASE, 1'b1, '0, ST_OK);
          phase_nxt = PH_ID_WAKE;
        end else if (!flag_r) begin
          res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_NOINIT);
          phase_nxt = PH_IDLE;
        end else if (bad) begin
          res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_BADARG);
          phase_nxt = PH_IDLE;
        end else begin
          addr_nxt = in_ch.address;
          left_nxt = (in_ch.operation == OP_ERASE) ? '0 : in_ch.length;
          pcnt_nxt = '0;
          if (limit_r == 20'd0) begin
            res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
            phase_nxt = PH_IDLE;
          end else begin
            res0      = mk_res(KIND_SPI, CMD_RDSR, 1'b0, '0, ST_OK);
            phase_nxt = PH_PRE_CMD;
          end
        end
      end
    end else if (in_ch.operation == OP_PG_BYTE) begin
      if (phase_r == PH_PG_WAIT) begin
        nres      = 2'd1;
        res0      = mk_res(KIND_SPI, b, left_r <= 24'd1, '0, ST_OK);
        phase_nxt = PH_PG_DATA;
      end
    end else if (in_ch.operation == OP_REPLY) begin
      nres = 2'd1;
      unique case (phase_r)
        PH_ID_WAKE: begin
          res0      = mk_res(KIND_SPI, CMD_JEDEC, 1'b0, '0, ST_OK);
          phase_nxt = PH_ID_CMD;
        end
        PH_ID_CMD: begin
          fidx_nxt  = 2'd0;
          res0      = mk_res(KIND_SPI, DUMMY_BYTE, 1'b0, '0, ST_OK);
          phase_nxt = PH_ID_BYTE;
        end
        PH_ID_BYTE: begin
          ident_nxt = id_new;
          if (fidx_r < 2'd2) begin
            fidx_nxt = fidx_r + 2'd1;
            res0     = mk_res(KIND_SPI, DUMMY_BYTE, fidx_r == 2'd1, '0, ST_OK);
          end else begin
            flag_nxt  = (id_new[23:16] == maker_r) && (id_new[7:0] == capc_r);
            res0      = mk_res(KIND_DONE, '0, 1'b0, id_new,
                               flag_nxt ? ST_OK : ST_MISMATCH);
            phase_nxt = PH_IDLE;
          end
        end
        PH_PRE_CMD: begin
          res0      = mk_res(KIND_SPI, DUMMY_BYTE, 1'b1, '0, ST_OK);
          phase_nxt = PH_PRE_ST;
        end
        PH_POST_CMD: begin
          res0      = mk_res(KIND_SPI, DUMMY_BYTE, 1'b1, '0, ST_OK);
          phase_nxt = PH_POST_ST;
        end
        PH_PRE_ST, PH_POST_ST: begin
          if (b[0]) begin
            pcnt_nxt = pcnt_inc;
            if (pcnt_inc >= limit_r) begin
              res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
              phase_nxt = PH_IDLE;
            end else begin
              res0      = mk_res(KIND_SPI, CMD_RDSR, 1'b0, '0, ST_OK);
              phase_nxt = (phase_r == PH_POST_ST) ? PH_POST_CMD : PH_PRE_CMD;
            end
          end else if (phase_r == PH_POST_ST) begin
            res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_OK);
            phase_nxt = PH_IDLE;
          end else if (preq_r == REQ_READ) begin
            res0      = mk_res(KIND_SPI, CMD_READ, 1'b0, '0, ST_OK);
            phase_nxt = PH_CMD;
          end else begin
            res0      = mk_res(KIND_SPI, CMD_WREN, 1'b1, '0, ST_OK);
            phase_nxt = PH_WREN;
          end
        end
        PH_WREN: begin
          res0      = mk_res(KIND_SPI, (preq_r == REQ_ERASE) ? CMD_SE : CMD_PP,
                             1'b0, '0, ST_OK);
          phase_nxt = PH_CMD;
        end
        PH_CMD: begin
          fidx_nxt  = 2'd0;
          res0      = mk_res(KIND_SPI, addr_r[23:16], 1'b0, '0, ST_OK);
          phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          if (fidx_r < 2'd2) begin
            fidx_nxt = fidx_r + 2'd1;
            res0     = mk_res(KIND_SPI, (fidx_r == 2'd0) ? addr_r[15:8] : addr_r[7:0],
                              (fidx_r == 2'd1) && (preq_r == REQ_ERASE), '0, ST_OK);
          end else if (preq_r == REQ_READ) begin
            res0      = mk_res(KIND_SPI, DUMMY_BYTE, left_r == 24'd1, '0, ST_OK);
            phase_nxt = PH_RD_DATA;
          end else if (preq_r == REQ_ERASE) begin
            pcnt_nxt = '0;
            if (limit_r == 20'd0) begin
              res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
              phase_nxt = PH_IDLE;
            end else begin
              res0      = mk_res(KIND_SPI, CMD_RDSR, 1'b0, '0, ST_OK);
              phase_nxt = PH_POST_CMD;
            end
          end else begin
            nres      = 2'd0;
            phase_nxt = PH_PG_WAIT;
          end
        end
        PH_RD_DATA: begin
          nres     = 2'd2;
          left_nxt = left_dec;
          res0     = mk_res(KIND_DATA, '0, 1'b0, {16'd0, b}, ST_OK);
          if (left_dec == 24'd0) begin
            res1      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_OK);
            phase_nxt = PH_IDLE;
          end else begin
            res1 = mk_res(KIND_SPI, DUMMY_BYTE, left_dec == 24'd1, '0, ST_OK);
          end
        end
        PH_PG_DATA: begin
          left_nxt = left_dec;
          if (left_dec == 24'd0) begin
            pcnt_nxt = '0;
            if (limit_r == 20'd0) begin
              res0      = mk_res(KIND_DONE, '0, 1'b0, '0, ST_TIMEOUT);
              phase_nxt = PH_IDLE;
            end else begin
              res0      = mk_res(KIND_SPI, CMD_RDSR, 1'b0, '0, ST_OK);
              phase_nxt = PH_POST_CMD;
            end
          end else begin
            nres      = 2'd0;
            phase_nxt = PH_PG_WAIT;
          end
        end
        default: begin
          nres = 2'd0;
        end
      endcase
    end
  end

  // Every beat reports the flag as it stands once this input is applied.
  always_comb begin
    r0f             = res0;
    r1f             = res1;
    r0f.initialized = flag_nxt;
    r1f.initialized = flag_nxt;
    r0f.last        = (nres == 2'd1);
    r1f.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      flag_r  <= 1'b0;
      ident_r <= '0;
      addr_r  <= '0;
      left_r  <= '0;
      pcnt_r  <= '0;
      fidx_r  <= '0;
      preq_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      flag_r  <= flag_nxt;
      ident_r <= ident_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      pcnt_r  <= pcnt_nxt;
      fidx_r  <= fidx_nxt;
      preq_r  <= preq_nxt;
    end
  end

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= POLL_LIMIT_RST;
      maker_r <= MAKER_RST;
      capc_r  <= CAPACITY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_POLL_LIMIT: limit_r <= cfg_ch.data;
        CFG_MAKER:      maker_r <= cfg_ch.data[7:0];
        CFG_CAPACITY:   capc_r  <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  snfcs_res_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (accept && (nres != 2'd0)),
    .push1     (accept && (nres == 2'd2)),
    .din0      (r0f),
    .din1      (r1f),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (head),
    .count     (qcount)
  );

  assign out_ch.kind        = head.kind;
  assign out_ch.mosi_byte   = head.mosi_byte;
  assign out_ch.frame_end   = head.frame_end;
  assign out_ch.value       = head.value;
  assign out_ch.status      = head.status;
  assign out_ch.initialized = head.initialized;
  assign out_ch.last        = head.last;

  // The result queue never overfills.
  a_qbound: assert property (@(posedge clk) disable iff (!rst_n) qcount <= 3'd4)
    else $error("result queue overfilled");

  // A request refused for lack of identity yields a beat on the next cycle.
  a_noinit: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && phase_r == PH_IDLE && !flag_r && in_ch.operation != OP_IDENTIFY &&
     in_ch.operation <= OP_PROGRAM) |=> out_ch.valid)
    else $error("refused request gave no result");

  // Frame byte index stays within the three-byte fields.
  a_fidx: assert property (@(posedge clk) disable iff (!rst_n) fidx_r != 2'd3)
    else $error("frame index out of range");

  // Waiting for program data means a positive byte count remains.
  a_pgwait: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PG_WAIT) |-> (left_r != 24'd0))
    else $error("program wait with no bytes left");

endmodule
